// File: rtl/sfmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfmc_pkg: shared definitions for the framed message CRC checker
// Types, register indexes, frame limits and the word-wise CRC-32 function.
// ----------------------------------------------------------------------------
package sfmc_pkg;

  localparam int unsigned MaxFrameBytes = 128;
  localparam int unsigned MinFrameBytes = 12;

  localparam logic [31:0] CrcPoly = 32'h04C1_1DB7;
  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;
  localparam int unsigned CrcWidth = 32;

  localparam int unsigned CfgIdxWidth = 3;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_SYNC_FIRST  = 3'd0,
    CFG_SYNC_SECOND = 3'd1,
    CFG_KIND_A_CODE = 3'd2,
    CFG_KIND_A_LEN  = 3'd3,
    CFG_KIND_B_CODE = 3'd4,
    CFG_KIND_B_LEN  = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_MARK2 = 3'd1,
    PH_VERLO = 3'd2,
    PH_VERHI = 3'd3,
    PH_CODE  = 3'd4,
    PH_BODY  = 3'd5
  } phase_e;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [7:0] kind_a_code;
    logic [7:0] kind_a_length;
    logic [7:0] kind_b_code;
    logic [7:0] kind_b_length;
  } cfg_t;

  typedef struct packed {
    logic        frame_status;
    logic        frame_kind;
    logic [15:0] frame_version;
    logic [31:0] crc_fail_total;
  } result_t;

  typedef logic [CrcWidth-1:0] crc_cols_t [CrcWidth];

  // Column i is the CRC register after one word step that starts from a
  // lone set bit i; the word step is linear, so any value is a sum of these.
  function automatic crc_cols_t crc_cols();
    crc_cols_t   cols;
    logic [31:0] c;
    for (int i = 0; i < CrcWidth; i++) begin
      c = 32'h1 << i;
      for (int k = 0; k < CrcWidth; k++) begin
        c = c[31] ? ((c << 1) ^ CrcPoly) : (c << 1);
      end
      cols[i] = c;
    end
    return cols;
  endfunction

  localparam crc_cols_t CrcCols = crc_cols();

  function automatic logic [31:0] crc_word(logic [31:0] crc, logic [31:0] word);
    logic [31:0] x;
    logic [31:0] r;
    x = crc ^ word;
    r = '0;
    for (int i = 0; i < CrcWidth; i++) begin
      if (x[i]) begin
        r = r ^ CrcCols[i];
      end
    end
    return r;
  endfunction

endpackage

// File: rtl/sfmc_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfmc_cfg_regs: configuration register file
// Holds the sync markers and the two message kinds with their lengths.
// ----------------------------------------------------------------------------
module sfmc_cfg_regs
  import sfmc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_index_i,
  input  logic [7:0]             cfg_wdata_i,
  output cfg_t                   cfg_o
);

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SYNC_FIRST:  cfg_d.sync_first    = cfg_wdata_i;
        CFG_SYNC_SECOND: cfg_d.sync_second   = cfg_wdata_i;
        CFG_KIND_A_CODE: cfg_d.kind_a_code   = cfg_wdata_i;
        CFG_KIND_A_LEN:  cfg_d.kind_a_length = cfg_wdata_i;
        CFG_KIND_B_CODE: cfg_d.kind_b_code   = cfg_wdata_i;
        CFG_KIND_B_LEN:  cfg_d.kind_b_length = cfg_wdata_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_first    <= 8'd0;
      cfg_q.sync_second   <= 8'd0;
      cfg_q.kind_a_code   <= 8'd1;
      cfg_q.kind_a_length <= 8'd0;
      cfg_q.kind_b_code   <= 8'd2;
      cfg_q.kind_b_length <= 8'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/sfmc_frame_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfmc_frame_core: frame parser and CRC engine
// Consumes one byte per step, tracks the frame phase, packs words, runs the
// word-wise CRC-32 and produces one result per completed frame.
// ----------------------------------------------------------------------------
module sfmc_frame_core
  import sfmc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] rx_byte_i,
  input  cfg_t       cfg_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  phase_e      phase_q, phase_d;
  logic [7:0]  byte_count_q, byte_count_d;
  logic [31:0] word_q, word_d;
  logic [31:0] crc_q, crc_d;
  logic [15:0] version_q, version_d;
  logic        kind_q, kind_d;
  logic [7:0]  frame_len_q, frame_len_d;
  logic [31:0] fail_q, fail_d;

  logic [31:0] word_next;
  logic [31:0] crc_next;
  logic        match_a, match_b;
  logic [7:0]  sel_len;
  logic        len_ok;
  logic        last_lane;
  logic        frame_done;
  logic        crc_bad;

  always_comb begin
    word_next = word_q;
    case (byte_count_q[1:0])
      2'd0:    word_next[7:0]   = rx_byte_i;
      2'd1:    word_next[15:8]  = rx_byte_i;
      2'd2:    word_next[23:16] = rx_byte_i;
      default: word_next[31:24] = rx_byte_i;
    endcase
  end

  assign crc_next   = crc_word(crc_q, word_next);
  assign match_a    = (rx_byte_i == cfg_i.kind_a_code);
  assign match_b    = (rx_byte_i == cfg_i.kind_b_code);
  assign sel_len    = match_a ? cfg_i.kind_a_length : cfg_i.kind_b_length;
  assign len_ok     = ({24'd0, sel_len} >= MinFrameBytes) &&
                      ({24'd0, sel_len} <= MaxFrameBytes) &&
                      (sel_len[1:0] == 2'b00);
  assign last_lane  = (byte_count_q[1:0] == 2'd3);
  assign frame_done = last_lane &&
                      (({1'b0, byte_count_q} + 9'd1) >= {1'b0, frame_len_q});
  assign crc_bad    = (word_next != crc_q);

  always_comb begin
    phase_d = phase_q;
    if (step_i) begin
      unique case (phase_q)
        PH_HUNT:  phase_d = (rx_byte_i == cfg_i.sync_first) ? PH_MARK2 : PH_HUNT;
        PH_MARK2: phase_d = (rx_byte_i == cfg_i.sync_second) ? PH_VERLO : PH_HUNT;
        PH_VERLO: phase_d = PH_VERHI;
        PH_VERHI: phase_d = PH_CODE;
        PH_CODE:  phase_d = ((match_a || match_b) && len_ok) ? PH_BODY : PH_HUNT;
        PH_BODY:  phase_d = frame_done ? PH_HUNT : PH_BODY;
        default:  phase_d = PH_HUNT;
      endcase
    end
  end

  always_comb begin
    byte_count_d = byte_count_q;
    word_d       = word_q;
    crc_d        = crc_q;
    version_d    = version_q;
    kind_d       = kind_q;
    frame_len_d  = frame_len_q;
    fail_d       = fail_q;
    res_valid_o  = 1'b0;
    if (step_i) begin
      unique case (phase_q)
        PH_HUNT: begin
          if (rx_byte_i == cfg_i.sync_first) begin
            byte_count_d = 8'd1;
            word_d       = {24'd0, rx_byte_i};
            crc_d        = CrcInit;
          end
        end
        PH_MARK2: begin
          if (rx_byte_i == cfg_i.sync_second) begin
            byte_count_d = 8'd2;
            word_d       = word_next;
          end else begin
            byte_count_d = 8'd0;
            word_d       = '0;
            crc_d        = CrcInit;
          end
        end
        PH_VERLO: begin
          version_d    = {8'd0, rx_byte_i};
          word_d       = word_next;
          byte_count_d = 8'd3;
        end
        PH_VERHI: begin
          version_d    = {rx_byte_i, version_q[7:0]};
          crc_d        = crc_next;
          word_d       = '0;
          byte_count_d = 8'd4;
        end
        PH_CODE: begin
          if (match_a || match_b) begin
            kind_d = !match_a;
          end
          if ((match_a || match_b) && len_ok) begin
            frame_len_d  = sel_len;
            word_d       = {24'd0, rx_byte_i};
            byte_count_d = 8'd5;
          end else begin
            byte_count_d = 8'd0;
            word_d       = '0;
            crc_d        = CrcInit;
          end
        end
        PH_BODY: begin
          byte_count_d = byte_count_q + 8'd1;
          if (!last_lane) begin
            word_d = word_next;
          end else if (frame_done) begin
            if (crc_bad && (fail_q != 32'hFFFF_FFFF)) begin
              fail_d = fail_q + 32'd1;
            end
            res_valid_o  = 1'b1;
            byte_count_d = 8'd0;
            word_d       = '0;
            crc_d        = CrcInit;
          end else begin
            crc_d  = crc_next;
            word_d = '0;
          end
        end
        default: begin
          byte_count_d = 8'd0;
          word_d       = '0;
          crc_d        = CrcInit;
        end
      endcase
    end
  end

  assign res_o.frame_status   = crc_bad;
  assign res_o.frame_kind     = kind_q;
  assign res_o.frame_version  = version_q;
  assign res_o.crc_fail_total = fail_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HUNT;
      byte_count_q <= 8'd0;
      word_q       <= '0;
      crc_q        <= CrcInit;
      version_q    <= '0;
      kind_q       <= 1'b0;
      frame_len_q  <= 8'd0;
      fail_q       <= '0;
    end else begin
      phase_q      <= phase_d;
      byte_count_q <= byte_count_d;
      word_q       <= word_d;
      crc_q        <= crc_d;
      version_q    <= version_d;
      kind_q       <= kind_d;
      frame_len_q  <= frame_len_d;
      fail_q       <= fail_d;
    end
  end

endmodule

// File: rtl/sync_framed_message_crc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_framed_message_crc_checker: framed message sync and CRC-32 check
// Hunts for two sync markers, decodes version and message code, and checks
// the word-wise CRC-32 of each frame against its last word.
// ----------------------------------------------------------------------------
// The block takes one received byte per cycle while the result output is not
// held, and can accept a new byte while a finished result still waits at the
// output. A byte is held in an input register and processed by the frame
// parser once the output can take a result; its combinational CRC-32 word
// step is the longest path. A result is loaded into the result register at
// the end of the cycle in which the parser takes the last byte of a frame.
// While a result waits unaccepted at the output, the parser holds and the
// input takes at most one more byte. Configuration is to be written only
// while no byte is in flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module sync_framed_message_crc_checker
  import sfmc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_index_i,
  input  logic [7:0]             cfg_wdata_i,
  input  logic                   rx_valid_i,
  output logic                   rx_ready_o,
  input  logic [7:0]             rx_byte_i,
  output logic                   res_valid_o,
  input  logic                   res_ready_i,
  output logic                   frame_status_o,
  output logic                   frame_kind_o,
  output logic [15:0]            frame_version_o,
  output logic [31:0]            crc_fail_total_o
);

  cfg_t    cfg;
  logic    in_valid_q;
  logic    [7:0] in_byte_q;
  logic    advance;
  logic    core_valid;
  result_t core_res;
  logic    out_valid_q;
  result_t out_q;

  sfmc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  assign advance    = in_valid_q && (!out_valid_q || res_ready_i);
  assign rx_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_valid_i && rx_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_valid_i && rx_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  sfmc_frame_core u_frame_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .rx_byte_i   (in_byte_q),
    .cfg_i       (cfg),
    .res_valid_o (core_valid),
    .res_o       (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (core_valid) begin
      out_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_valid) begin
      out_q <= core_res;
    end
  end

  assign res_valid_o      = out_valid_q;
  assign frame_status_o   = out_q.frame_status;
  assign frame_kind_o     = out_q.frame_kind;
  assign frame_version_o  = out_q.frame_version;
  assign crc_fail_total_o = out_q.crc_fail_total;

endmodule

// File: tb/sv/tb_sync_framed_message_crc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sync_framed_message_crc_checker: self-checking bench for the frame checker
// Streams byte sequences through the checker under changing marker, code and
// length settings and compares every frame result with the results predicted
// by a scoreboard that tracks the hunt, header and CRC state byte by byte.
// ----------------------------------------------------------------------------
import sfmc_pkg::*;

class frame_scoreboard;
  cfg_t        regs;
  phase_e      phase;
  logic [7:0]  count;
  logic [31:0] word;
  logic [31:0] crc;
  logic [15:0] version;
  logic        kind;
  logic [7:0]  length;
  logic [31:0] fails;
  result_t     expected_q[$];
  int          errors;

  function new();
    regs = '{sync_first: 8'h00, sync_second: 8'h00, kind_a_code: 8'h01,
             kind_a_length: 8'h00, kind_b_code: 8'h02, kind_b_length: 8'h00};
    restart();
    version  = '0;
    kind     = 1'b0;
    length   = '0;
    fails    = '0;
    errors   = 0;
  endfunction

  function logic [31:0] crc_step(logic [31:0] c, logic [31:0] w);
    logic [31:0] r;
    r = c ^ w;
    for (int i = 0; i < 32; i++) begin
      r = r[31] ? ((r << 1) ^ CrcPoly) : (r << 1);
    end
    return r;
  endfunction

  function bit len_ok(logic [7:0] len);
    return (len >= MinFrameBytes) && (len <= MaxFrameBytes) && (len[1:0] == 2'b00);
  endfunction

  function void restart();
    phase = PH_HUNT;
    count = '0;
    word  = '0;
    crc   = CrcInit;
  endfunction

  function void set_reg(cfg_idx_e idx, logic [7:0] v);
    case (idx)
      CFG_SYNC_FIRST:  regs.sync_first    = v;
      CFG_SYNC_SECOND: regs.sync_second   = v;
      CFG_KIND_A_CODE: regs.kind_a_code   = v;
      CFG_KIND_A_LEN:  regs.kind_a_length = v;
      CFG_KIND_B_CODE: regs.kind_b_code   = v;
      CFG_KIND_B_LEN:  regs.kind_b_length = v;
      default: ;
    endcase
  endfunction

  // Advances the frame state by one accepted byte transfer.
  function void note_byte(logic [7:0] b);
    logic [7:0] len;
    logic [1:0] lane;
    bit         known;
    result_t    r;
    case (phase)
      PH_HUNT: begin
        if (b == regs.sync_first) begin
          phase = PH_MARK2;
          count = 8'd1;
          word  = {24'h0, b};
          crc   = CrcInit;
        end
      end
      PH_MARK2: begin
        if (b == regs.sync_second) begin
          phase      = PH_VERLO;
          count      = 8'd2;
          word[15:8] = b;
        end else begin
          restart();
        end
      end
      PH_VERLO: begin
        version     = {8'h00, b};
        word[23:16] = b;
        count       = 8'd3;
        phase       = PH_VERHI;
      end
      PH_VERHI: begin
        version[15:8] = b;
        word[31:24]   = b;
        crc           = crc_step(crc, word);
        word          = '0;
        count         = 8'd4;
        phase         = PH_CODE;
      end
      PH_CODE: begin
        known = 1'b1;
        len   = '0;
        if (b == regs.kind_a_code) begin
          kind = 1'b0;
          len  = regs.kind_a_length;
        end else if (b == regs.kind_b_code) begin
          kind = 1'b1;
          len  = regs.kind_b_length;
        end else begin
          known = 1'b0;
        end
        if (!known || !len_ok(len)) begin
          restart();
        end else begin
          length = len;
          word   = {24'h0, b};
          count  = 8'd5;
          phase  = PH_BODY;
        end
      end
      PH_BODY: begin
        lane = count[1:0];
        word[8*lane +: 8] = b;
        count = count + 8'd1;
        if (lane == 2'd3) begin
          if (count >= length) begin
            r.frame_status = (word != crc);
            if (r.frame_status && fails != 32'hFFFF_FFFF) begin
              fails = fails + 32'd1;
            end
            r.frame_kind     = kind;
            r.frame_version  = version;
            r.crc_fail_total = fails;
            expected_q.insert(expected_q.size(), r);
            restart();
          end else begin
            crc  = crc_step(crc, word);
            word = '0;
          end
        end
      end
      default: restart();
    endcase
  endfunction

  function void check_result(result_t got);
    result_t want;
    if (expected_q.size() == 0) begin
      $display("%0t: result with no frame pending: expected none, actual %h", $time, got);
      errors++;
    end else begin
      want = expected_q[0];
      expected_q.delete(0);
      if (got.frame_status != want.frame_status) begin
        $display("%0t: frame_status expected %0d actual %0d", $time,
                 want.frame_status, got.frame_status);
        errors++;
      end
      if (got.frame_kind != want.frame_kind) begin
        $display("%0t: frame_kind expected %0d actual %0d", $time,
                 want.frame_kind, got.frame_kind);
        errors++;
      end
      if (got.frame_version != want.frame_version) begin
        $display("%0t: frame_version expected %h actual %h", $time,
                 want.frame_version, got.frame_version);
        errors++;
      end
      if (got.crc_fail_total != want.crc_fail_total) begin
        $display("%0t: crc_fail_total expected %0d actual %0d", $time,
                 want.crc_fail_total, got.crc_fail_total);
        errors++;
      end
    end
  endfunction
endclass

module tb_sync_framed_message_crc_checker;

  localparam int HoldCycles      = 300;
  localparam int BytesPerSetting = 40;
  localparam int RandomSettings  = 12;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_index_i = '0;
  logic [7:0]             cfg_wdata_i = '0;
  logic                   rx_valid_i = 1'b0;
  logic                   rx_ready_o;
  logic [7:0]             rx_byte_i = '0;
  logic                   res_valid_o;
  logic                   res_ready_i = 1'b0;
  logic                   frame_status_o;
  logic                   frame_kind_o;
  logic [15:0]            frame_version_o;
  logic [31:0]            crc_fail_total_o;

  frame_scoreboard board;
  logic [7:0]      frame_bytes[$];
  int              send_idle_pct = 0;
  int              recv_idle_pct = 0;
  bit              hold_req = 1'b0;
  int              sent_bytes = 0;

  sync_framed_message_crc_checker u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .rx_valid_i      (rx_valid_i),
    .rx_ready_o      (rx_ready_o),
    .rx_byte_i       (rx_byte_i),
    .res_valid_o     (res_valid_o),
    .res_ready_i     (res_ready_i),
    .frame_status_o  (frame_status_o),
    .frame_kind_o    (frame_kind_o),
    .frame_version_o (frame_version_o),
    .crc_fail_total_o(crc_fail_total_o)
  );

  always #2 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("tb_sync_framed_message_crc_checker: FAIL");
    $finish;
  end

  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        res_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end
      res_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && res_valid_o && res_ready_i) begin
      board.check_result({frame_status_o, frame_kind_o, frame_version_o, crc_fail_total_o});
    end
  end

  task automatic send_byte(input logic [7:0] b);
    bit ok;
    while ($urandom_range(99) < send_idle_pct) begin
      rx_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do begin
      @(negedge clk_i);
      ok = rx_ready_o;
      @(posedge clk_i);
    end while (!ok);
    board.note_byte(b);
    sent_bytes++;
  endtask

  task automatic build_frame(input logic [7:0] code, input logic [7:0] len,
                             input logic [15:0] ver, input bit corrupt);
    logic [31:0] c;
    frame_bytes = {board.regs.sync_first, board.regs.sync_second, ver[7:0], ver[15:8], code};
    if (board.len_ok(len)) begin
      while (frame_bytes.size() < int'(len) - 4) begin
        frame_bytes.insert(frame_bytes.size(), 8'($urandom_range(255)));
      end
      c = CrcInit;
      for (int i = 0; i < frame_bytes.size(); i += 4) begin
        c = board.crc_step(c, {frame_bytes[i+3], frame_bytes[i+2],
                               frame_bytes[i+1], frame_bytes[i]});
      end
      if (corrupt) begin
        c = c ^ (32'h1 << $urandom_range(31));
      end
      for (int i = 0; i < 4; i++) begin
        frame_bytes.insert(frame_bytes.size(), c[8*i +: 8]);
      end
    end
  endtask

  task automatic send_span(input int first, input int last);
    for (int i = first; i < last && i < frame_bytes.size(); i++) begin
      send_byte(frame_bytes[i]);
    end
  endtask

  task automatic send_frame(input logic [7:0] code, input logic [7:0] len,
                            input logic [15:0] ver, input bit corrupt, input int cut);
    build_frame(code, len, ver, corrupt);
    send_span(0, frame_bytes.size() - cut);
  endtask

  // Bytes with no result may still be in the input and parser stages.
  task automatic wait_drain();
    rx_valid_i <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [7:0] v);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_reg(idx, v);
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [7:0] sf, input logic [7:0] ss,
                            input logic [7:0] ac, input logic [7:0] al,
                            input logic [7:0] bc, input logic [7:0] bl);
    wait_drain();
    write_reg(CFG_SYNC_FIRST, sf);
    write_reg(CFG_SYNC_SECOND, ss);
    write_reg(CFG_KIND_A_CODE, ac);
    write_reg(CFG_KIND_A_LEN, al);
    write_reg(CFG_KIND_B_CODE, bc);
    write_reg(CFG_KIND_B_LEN, bl);
  endtask

  function automatic logic [7:0] pick_len();
    int r;
    r = $urandom_range(19);
    if (r == 0) return 8'(MaxFrameBytes);
    if (r == 1) return 8'($urandom_range(255));
    return 8'(MinFrameBytes + 4 * $urandom_range(5));
  endfunction

  task automatic random_setting();
    logic [7:0] ac;
    logic [7:0] bc;
    ac = 8'($urandom);
    bc = ($urandom_range(7) == 0) ? ac : 8'($urandom);
    set_config(8'($urandom), 8'($urandom), ac, pick_len(), bc, pick_len());
  endtask

  task automatic random_sequence();
    int         r;
    bit         use_b;
    logic [7:0] code;
    logic [7:0] len;
    logic [7:0] other;
    r     = $urandom_range(99);
    use_b = $urandom_range(1) && (board.regs.kind_b_code != board.regs.kind_a_code);
    code  = use_b ? board.regs.kind_b_code : board.regs.kind_a_code;
    len   = use_b ? board.regs.kind_b_length : board.regs.kind_a_length;
    if (r < 70) begin
      send_frame(code, len, 16'($urandom), $urandom_range(5) == 0, 0);
    end else if (r < 78) begin
      send_frame(code, len, 16'($urandom), 1'b0, $urandom_range(1, 8));
    end else if (r < 84) begin
      other = $urandom_range(1) ? board.regs.sync_first : 8'($urandom);
      if (other == board.regs.sync_second) other = other + 8'd1;
      send_byte(board.regs.sync_first);
      send_byte(other);
      repeat ($urandom_range(0, 4)) send_byte(8'($urandom));
    end else if (r < 90) begin
      other = 8'($urandom);
      while (other == board.regs.kind_a_code || other == board.regs.kind_b_code) begin
        other = other + 8'd1;
      end
      send_frame(other, 8'd12, 16'($urandom), 1'b0, 7);
    end else begin
      repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
    end
  endtask

  initial begin
    int         start;
    int         regime;
    logic [7:0] bad_lens[5];
    board = new();
    send_idle_pct = 29;
    recv_idle_pct = 74;
    bad_lens = '{8'd8, 8'd13, 8'd132, 8'd255, 8'd0};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_frame(board.regs.kind_a_code, 8'd12, 16'h1234, 1'b0, 0);
    set_config(8'hFF, 8'h00, 8'h00, 8'(MinFrameBytes), 8'hFF, 8'(MaxFrameBytes));
    send_frame(8'h00, 8'(MinFrameBytes), 16'hFFFF, 1'b0, 0);
    send_frame(8'hFF, 8'(MaxFrameBytes), 16'h0000, 1'b1, 0);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_frame(8'h5A, 8'd12, 16'h00FF, 1'b0, 7);
    set_config(8'hFF, 8'h00, 8'h00, 8'd12, 8'h00, 8'd16);
    send_frame(8'h00, 8'd12, 16'h8001, 1'b0, 0);
    foreach (bad_lens[i]) begin
      wait_drain();
      write_reg(CFG_KIND_A_LEN, bad_lens[i]);
      send_frame(8'h00, 8'd12, 16'h0F0F, 1'b0, 7);
    end
    wait_drain();
    write_reg(CFG_KIND_A_LEN, 8'd16);
    build_frame(8'h00, 8'd16, 16'hA55A, 1'b0);
    send_span(0, 6);
    wait_drain();
    write_reg(CFG_KIND_A_LEN, 8'd12);
    write_reg(CFG_SYNC_FIRST, 8'h5A);
    send_span(6, 16);
    send_frame(8'h00, 8'd12, 16'h7FFE, 1'b0, 0);

    for (int k = 0; k < RandomSettings; k++) begin
      regime = (k < 4) ? 0 : (k < 8) ? 1 : 2;
      send_idle_pct = (regime == 0) ? 29 : (regime == 1) ? 74 : 0;
      recv_idle_pct = (regime == 0) ? 74 : (regime == 1) ? 29 : 0;
      random_setting();
      if (k == 1 || k == 9) begin
        hold_req = 1'b1;
      end
      start = sent_bytes;
      while (sent_bytes - start < BytesPerSetting) random_sequence();
    end

    wait_drain();
    repeat (8) @(posedge clk_i);
    if (board.errors == 0 && board.expected_q.size() == 0) begin
      $display("tb_sync_framed_message_crc_checker: PASS");
    end else begin
      $display("tb_sync_framed_message_crc_checker: FAIL");
    end
    $finish;
  end

endmodule
